[rtl/bsw_pkg.sv]
// Shared types and constants for the batched stop-and-wait sender.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package bsw_pkg;

  // Field widths fixed by the interface.
  localparam int CNT_W    = 7;
  localparam int SEQ_W    = 16;
  localparam int ENTRY_W  = 16;
  localparam int SLOT_W   = 2;
  localparam int MAX_SLOTS = 4;

  // Input modes.
  localparam logic [2:0] MODE_ADD   = 3'd0;
  localparam logic [2:0] MODE_FLUSH = 3'd1;
  localparam logic [2:0] MODE_CLOSE = 3'd2;
  localparam logic [2:0] MODE_ACK   = 3'd3;
  localparam logic [2:0] MODE_TICK  = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_DEST_CHIP = 1'b0;
  localparam logic CFG_DEST_CORE = 1'b1;

  // Result kinds.
  localparam logic KIND_PIECE  = 1'b0;
  localparam logic KIND_REFUSE = 1'b1;

  // Sequence number after reset, so that the first packet carries zero.
  localparam logic [SEQ_W-1:0] SEQ_RESET = 16'hFFFF;

  // Upper bits of the expected acknowledgement port (32 plus the core).
  localparam logic [2:0] ACK_PORT_BASE = 3'b001;

  // Protocol phase.
  typedef enum logic [2:0] {
    PH_COLLECT,
    PH_HOLD,
    PH_CLOSE_HOLD,
    PH_CLOSE_WAIT,
    PH_END_WAIT,
    PH_DONE
  } phase_t;

  // Sequencer states of the controller.
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_READ,
    CS_CAP,
    CS_PUT,
    CS_REFUSE
  } ctl_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic              add;
    logic              send;
    logic              emit_start;
    logic              rd_issue;
    logic [SLOT_W-1:0] rd_slot;
    logic              load_piece;
    logic              load_refuse;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic ack_match;
    logic collect_zero;
    logic collect_fill;
    logic rd_more;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/batched_stop_and_wait_sender_core.sv]
// Top level of the batched stop-and-wait sender: controller plus datapath.
// Depends on bsw_pkg, bsw_ctrl, bsw_dpath and bsw_ram.
//
// Usage. The input channel (in_valid / in_stall) carries one command per
// transfer: add an entry, flush, close, acknowledgement or timer tick. The
// result channel (out_valid / out_stall) carries packet pieces of up to
// ENTRIES_PER_PIECE entries, or a single refusal when an add arrives while
// the batch cannot take it. dest_chip and dest_core are written through
// cfg_we / cfg_index / cfg_wdata while the block is idle.
// Results. A transfer that produces no result leaves in_stall low. A transmitted
// packet of n entries has max(1, ceil(n / ENTRIES_PER_PIECE)) pieces; each
// piece is read one entry per slot through the single read port of the
// entry memory, captured, then put into the output register once it is free.
// A refusal is likewise loaded into the output register once it is free.
// in_stall is high while pieces or a refusal are being produced.
// The last result sits in the output register, so the next command is taken
// while it waits. A stalled receiver holds the current result and the
// sequencer waits for the register to free up.
// Reset (rst_n low, synchronous) empties the batch, marks nothing
// outstanding, sets the sequence number so the first packet carries zero
// and clears both configuration registers. No memory clearing is needed.
`default_nettype none

module batched_stop_and_wait_sender_core #(
  parameter int PACKET_ENTRIES    = 127,
  parameter int ENTRIES_PER_PIECE = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_neuron_index,
  input  wire logic [7:0]  in_delay_stage,
  input  wire logic [15:0] in_ack_sequence,
  input  wire logic [15:0] in_ack_source_chip,
  input  wire logic [7:0]  in_ack_source_port,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [15:0]      out_packet_sequence,
  output logic [6:0]       out_packet_count,
  output logic [15:0]      out_entry_a,
  output logic [15:0]      out_entry_b,
  output logic [15:0]      out_entry_c,
  output logic [15:0]      out_entry_d,
  output logic             out_piece_last
);

  import bsw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bsw_ctrl #(
    .ENTRIES_PER_PIECE (ENTRIES_PER_PIECE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsw_dpath #(
    .PACKET_ENTRIES (PACKET_ENTRIES)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_neuron_index     (in_neuron_index),
    .in_delay_stage      (in_delay_stage),
    .in_ack_sequence     (in_ack_sequence),
    .in_ack_source_chip  (in_ack_source_chip),
    .in_ack_source_port  (in_ack_source_port),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_packet_sequence (out_packet_sequence),
    .out_packet_count    (out_packet_count),
    .out_entry_a         (out_entry_a),
    .out_entry_b         (out_entry_b),
    .out_entry_c         (out_entry_c),
    .out_entry_d         (out_entry_d),
    .out_piece_last      (out_piece_last)
  );

endmodule

`default_nettype wire

[rtl/bsw_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the datapath for the two entry banks.
`default_nettype none

module bsw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/bsw_ctrl.sv]
// Controller: protocol phase, acknowledgement flag and the piece sequencer.
// Depends on bsw_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module bsw_ctrl #(
  parameter int ENTRIES_PER_PIECE = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [2:0]    in_mode,
  output logic               in_stall,
  input  wire bsw_pkg::sts_t sts,
  output bsw_pkg::cmd_t      cmd
);

  import bsw_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES_PER_PIECE - 1);

  ctl_state_t        state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic              acked_r, acked_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic in_acc;
  logic d_add, d_send, d_emit, d_refuse;

  assign in_stall = (state_r != CS_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Decode of an accepted transfer against the current phase.
  always_comb begin
    d_add     = 1'b0;
    d_send    = 1'b0;
    d_emit    = 1'b0;
    d_refuse  = 1'b0;
    phase_nxt = phase_r;
    acked_nxt = acked_r;
    if (in_acc) begin
      case (in_mode)
        MODE_ADD: begin
          if (phase_r != PH_COLLECT) begin
            d_refuse = 1'b1;
          end else begin
            d_add = 1'b1;
            if (sts.collect_fill) begin
              if (acked_r) begin
                d_send = 1'b1;
              end else begin
                phase_nxt = PH_HOLD;
              end
            end
          end
        end
        MODE_FLUSH: begin
          if (phase_r == PH_COLLECT && !sts.collect_zero) begin
            if (acked_r) begin
              d_send = 1'b1;
            end else begin
              phase_nxt = PH_HOLD;
            end
          end
        end
        MODE_CLOSE: begin
          if (phase_r == PH_HOLD) begin
            phase_nxt = PH_CLOSE_HOLD;
          end else if (phase_r == PH_COLLECT) begin
            if (!sts.collect_zero) begin
              if (acked_r) begin
                d_send    = 1'b1;
                phase_nxt = PH_CLOSE_WAIT;
              end else begin
                phase_nxt = PH_CLOSE_HOLD;
              end
            end else if (acked_r) begin
              d_send    = 1'b1;
              phase_nxt = PH_END_WAIT;
            end else begin
              phase_nxt = PH_CLOSE_WAIT;
            end
          end
        end
        MODE_ACK: begin
          if (phase_r != PH_DONE && sts.ack_match) begin
            acked_nxt = 1'b1;
            case (phase_r)
              PH_HOLD: begin
                d_send    = 1'b1;
                phase_nxt = PH_COLLECT;
              end
              PH_CLOSE_HOLD: begin
                d_send    = 1'b1;
                phase_nxt = PH_CLOSE_WAIT;
              end
              PH_CLOSE_WAIT: begin
                d_send    = 1'b1;
                phase_nxt = PH_END_WAIT;
              end
              PH_END_WAIT: begin
                phase_nxt = PH_DONE;
              end
              default: begin
                phase_nxt = phase_r;
              end
            endcase
          end
        end
        MODE_TICK: begin
          if (!acked_r &&
              (phase_r inside {PH_HOLD, PH_CLOSE_HOLD, PH_CLOSE_WAIT, PH_END_WAIT})) begin
            d_emit = 1'b1;
          end
        end
        default: begin
          d_emit = 1'b0;
        end
      endcase
      // A send always leaves the new packet outstanding and transmits it.
      if (d_send) begin
        acked_nxt = 1'b0;
        d_emit    = 1'b1;
      end
    end
  end

  // Next state of the piece sequencer.
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    case (state_r)
      CS_IDLE: begin
        slot_nxt = '0;
        if (d_refuse) begin
          state_nxt = CS_REFUSE;
        end else if (d_emit) begin
          state_nxt = CS_READ;
        end
      end
      CS_READ: begin
        if (slot_r == LAST_SLOT) begin
          slot_nxt  = '0;
          state_nxt = CS_CAP;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      CS_CAP: begin
        state_nxt = CS_PUT;
      end
      CS_PUT: begin
        if (sts.out_free) begin
          state_nxt = sts.rd_more ? CS_READ : CS_IDLE;
        end
      end
      CS_REFUSE: begin
        if (sts.out_free) begin
          state_nxt = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd             = '0;
    cmd.add         = d_add;
    cmd.send        = d_send;
    cmd.emit_start  = d_emit;
    cmd.rd_slot     = slot_r;
    cmd.rd_issue    = (state_r == CS_READ) && sts.rd_more;
    cmd.load_piece  = (state_r == CS_PUT) && sts.out_free;
    cmd.load_refuse = (state_r == CS_REFUSE) && sts.out_free;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      phase_r <= PH_COLLECT;
      acked_r <= 1'b1;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      acked_r <= acked_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // The end packet is acknowledged before the block reports itself finished.
  a_done_acked: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> acked_r)
    else $error("finished while a packet is outstanding");

  // A held send only exists while the previous packet is outstanding.
  a_hold_unacked: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HOLD || phase_r == PH_CLOSE_HOLD) |-> !acked_r)
    else $error("send held although nothing is outstanding");

  // A send always starts a transmission of the new packet.
  a_send_emits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.send |=> state_r == CS_READ && !acked_r)
    else $error("send did not start a transmission");

endmodule

`default_nettype wire

[rtl/bsw_dpath.sv]
// Datapath: entry banks, counts, sequence number, configuration and the
// output register. Depends on bsw_pkg and bsw_ram.
`default_nettype none

module bsw_dpath #(
  parameter int PACKET_ENTRIES = 127
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [15:0]                    cfg_wdata,
  input  wire logic [7:0]                     in_neuron_index,
  input  wire logic [7:0]                     in_delay_stage,
  input  wire logic [15:0]                    in_ack_sequence,
  input  wire logic [15:0]                    in_ack_source_chip,
  input  wire logic [7:0]                     in_ack_source_port,
  input  wire bsw_pkg::cmd_t                  cmd,
  output bsw_pkg::sts_t                       sts,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_kind,
  output logic [bsw_pkg::SEQ_W-1:0]           out_packet_sequence,
  output logic [bsw_pkg::CNT_W-1:0]           out_packet_count,
  output logic [bsw_pkg::ENTRY_W-1:0]         out_entry_a,
  output logic [bsw_pkg::ENTRY_W-1:0]         out_entry_b,
  output logic [bsw_pkg::ENTRY_W-1:0]         out_entry_c,
  output logic [bsw_pkg::ENTRY_W-1:0]         out_entry_d,
  output logic                                out_piece_last
);

  import bsw_pkg::*;

  localparam int IDX_W     = $clog2(PACKET_ENTRIES);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  // Configuration registers.
  logic [15:0] dest_chip_r;
  logic [4:0]  dest_core_r;

  // Batch state. bank_r selects the collecting half; the other half is in flight.
  logic [CNT_W-1:0] collect_count_r;
  logic [CNT_W-1:0] flight_count_r;
  logic [SEQ_W-1:0] seq_r;
  logic             bank_r;

  // Piece assembly.
  logic [CNT_W-1:0]   rd_ptr_r;
  logic               cap_vld_r;
  logic [SLOT_W-1:0]  cap_slot_r;
  logic [ENTRY_W-1:0] asm_r [MAX_SLOTS];

  // Output register.
  logic               out_valid_r;
  logic               out_kind_r;
  logic [SEQ_W-1:0]   out_seq_r;
  logic [CNT_W-1:0]   out_count_r;
  logic [ENTRY_W-1:0] out_ent_r [MAX_SLOTS];
  logic               out_last_r;

  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic [CNT_W-1:0]   count_after_add;

  assign wdata = {in_delay_stage, in_neuron_index};
  assign waddr = {bank_r, collect_count_r[IDX_W-1:0]};
  assign raddr = {~bank_r, rd_ptr_r[IDX_W-1:0]};
  assign count_after_add = cmd.add ? collect_count_r + CNT_W'(1) : collect_count_r;

  bsw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.add),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status towards the controller.
  always_comb begin
    sts.ack_match    = (in_ack_sequence == seq_r) &&
                       (in_ack_source_chip == dest_chip_r) &&
                       (in_ack_source_port == {ACK_PORT_BASE, dest_core_r});
    sts.collect_zero = (collect_count_r == '0);
    sts.collect_fill = (collect_count_r >= CNT_W'(PACKET_ENTRIES - 1));
    sts.rd_more      = (rd_ptr_r < flight_count_r);
    sts.out_free     = !out_valid_r || !out_stall;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_chip_r <= '0;
      dest_core_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEST_CHIP: dest_chip_r <= cfg_wdata;
        CFG_DEST_CORE: dest_core_r <= cfg_wdata[4:0];
        default:       dest_chip_r <= dest_chip_r;
      endcase
    end
  end

  // Counts on an add; counts, sequence number and bank swap on a send.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collect_count_r <= '0;
      flight_count_r  <= '0;
      seq_r           <= SEQ_RESET;
      bank_r          <= 1'b0;
    end else if (cmd.send) begin
      flight_count_r  <= count_after_add;
      collect_count_r <= '0;
      seq_r           <= seq_r + SEQ_W'(1);
      bank_r          <= ~bank_r;
    end else begin
      collect_count_r <= count_after_add;
    end
  end

  // Read pointer and capture of read data into the piece slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r  <= '0;
      cap_vld_r <= 1'b0;
    end else begin
      cap_vld_r <= cmd.rd_issue;
      if (cmd.emit_start) begin
        rd_ptr_r <= '0;
      end else if (cmd.rd_issue) begin
        rd_ptr_r <= rd_ptr_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_slot_r <= cmd.rd_slot;
    if (cmd.emit_start || cmd.load_piece) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        asm_r[i] <= '0;
      end
    end else if (cap_vld_r) begin
      asm_r[cap_slot_r] <= rdata;
    end
  end

  // Output register; a new result is loaded only when the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_piece || cmd.load_refuse) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_piece) begin
      out_kind_r  <= KIND_PIECE;
      out_seq_r   <= seq_r;
      out_count_r <= flight_count_r;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        out_ent_r[i] <= asm_r[i];
      end
      out_last_r  <= !sts.rd_more;
    end else if (cmd.load_refuse) begin
      out_kind_r  <= KIND_REFUSE;
      out_seq_r   <= '0;
      out_count_r <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        out_ent_r[i] <= '0;
      end
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_packet_sequence = out_seq_r;
  assign out_packet_count    = out_count_r;
  assign out_entry_a         = out_ent_r[0];
  assign out_entry_b         = out_ent_r[1];
  assign out_entry_c         = out_ent_r[2];
  assign out_entry_d         = out_ent_r[3];
  assign out_piece_last      = out_last_r;

  // The collecting batch never grows beyond one packet.
  a_collect_bound: assert property (@(posedge clk) disable iff (!rst_n)
    collect_count_r <= CNT_W'(PACKET_ENTRIES))
    else $error("collect count beyond packet size");

  // A refusal appears in the output register on the next cycle.
  a_refuse_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_refuse |=> out_valid_r && out_kind_r == KIND_REFUSE && out_last_r)
    else $error("refusal not presented");

  // A result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(cmd.load_piece || cmd.load_refuse))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for batched_stop_and_wait_sender_core.
// Depends on bsw_pkg and the core; drives commands, predicts every packet piece
// and refusal in a behavioural copy of the sender, and checks each result transfer.
`timescale 1ns / 1ps

module testbench;
  import bsw_pkg::*;

  localparam int PER_PIECE     = 4;
  localparam int BATCH_MAX     = 127;
  localparam int MAX_WAIT      = 11;
  localparam int SETTLE_CYCLES = 40;
  localparam int END_CYCLES    = 250;
  localparam int CYCLE_LIMIT   = 1_500_000;

  // Modes that the sender does not define.
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  // How the acknowledgement fields of a command are filled when it is driven.
  typedef enum {AK_RAW, AK_GOOD, AK_SEQ_OFF, AK_CHIP_OFF, AK_PORT_OFF} ack_form_t;

  // Ways of closing the stream at the end of the run.
  typedef enum {
    END_EMPTY, END_REMAINDER, END_BEHIND_ACK, END_BEHIND_HOLD, END_EMPTY_UNACKED
  } close_path_t;

  typedef struct {
    logic [2:0]  mode;
    logic [7:0]  idx;
    logic [7:0]  stage;
    logic [15:0] aseq;
    logic [15:0] achip;
    logic [7:0]  aport;
    ack_form_t   form;
  } cmd_item_t;

  typedef struct packed {
    logic                        kind;
    logic [15:0]                 seq;
    logic [6:0]                  cnt;
    logic [PER_PIECE-1:0][15:0]  ent;
    logic                        last;
  } piece_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = MODE_TICK;
  logic [7:0]  in_neuron_index = '0;
  logic [7:0]  in_delay_stage = '0;
  logic [15:0] in_ack_sequence = '0;
  logic [15:0] in_ack_source_chip = '0;
  logic [7:0]  in_ack_source_port = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [15:0] out_packet_sequence;
  logic [6:0]  out_packet_count;
  logic [15:0] out_entry_a;
  logic [15:0] out_entry_b;
  logic [15:0] out_entry_c;
  logic [15:0] out_entry_d;
  logic        out_piece_last;

  batched_stop_and_wait_sender_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_neuron_index     (in_neuron_index),
    .in_delay_stage      (in_delay_stage),
    .in_ack_sequence     (in_ack_sequence),
    .in_ack_source_chip  (in_ack_source_chip),
    .in_ack_source_port  (in_ack_source_port),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_packet_sequence (out_packet_sequence),
    .out_packet_count    (out_packet_count),
    .out_entry_a         (out_entry_a),
    .out_entry_b         (out_entry_b),
    .out_entry_c         (out_entry_c),
    .out_entry_d         (out_entry_d),
    .out_piece_last      (out_piece_last)
  );

  // Commands waiting to be driven and pieces the sender still owes.
  cmd_item_t cmds_waiting[$];
  piece_t    pieces_due[$];

  // Behavioural copy of the sender state and its destination registers.
  logic [15:0] batch_mem  [0:BATCH_MAX-1];
  logic [15:0] flight_mem [0:BATCH_MAX-1];
  int          batch_len;
  int          flight_len;
  logic [15:0] seq_now;
  logic        acked_now;
  phase_t      ph;
  logic [15:0] want_chip;
  logic [4:0]  want_core;

  // Handshake flags sampled at the rising edge, used by the falling-edge drivers.
  bit in_took  = 1'b0;
  bit res_took = 1'b0;
  bit calm_in  = 1'b0;
  bit calm_out = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  int errors = 0;
  int cycle_count = 0;
  int cmds_taken = 0;
  int pieces_seen = 0;
  int packets_seen = 0;
  int full_packets = 0;
  int refusals_seen = 0;
  close_path_t ending;

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Reporting

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 100) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Prediction of the sender

  // Queue every piece of the packet currently in flight.
  function automatic void queue_flight_copy();
    int npieces;
    piece_t p;
    npieces = (flight_len + PER_PIECE - 1) / PER_PIECE;
    if (npieces == 0) npieces = 1;
    for (int i = 0; i < npieces; i++) begin
      p = '0;
      p.kind = KIND_PIECE;
      p.seq = seq_now;
      p.cnt = 7'(flight_len);
      for (int j = 0; j < PER_PIECE; j++)
        if (i * PER_PIECE + j < flight_len) p.ent[j] = flight_mem[i * PER_PIECE + j];
      p.last = (i == npieces - 1);
      pieces_due.push_back(p);
    end
  endfunction

  // Turn the collected batch (possibly empty, giving the end packet) into a packet.
  function automatic void launch_batch();
    seq_now = seq_now + 16'd1;
    for (int k = 0; k < batch_len; k++) flight_mem[k] = batch_mem[k];
    flight_len = batch_len;
    batch_len = 0;
    acked_now = 1'b0;
    queue_flight_copy();
  endfunction

  function automatic void try_flush();
    if (batch_len == 0) return;
    if (acked_now) launch_batch();
    else ph = PH_HOLD;
  endfunction

  function automatic void sender_advance(logic [2:0] mode, logic [7:0] idx, logic [7:0] stage,
                                         logic [15:0] aseq, logic [15:0] achip,
                                         logic [7:0] aport);
    piece_t refusal;
    refusal = '0;
    refusal.kind = KIND_REFUSE;
    refusal.last = 1'b1;
    case (mode)
      MODE_ADD: begin
        if (ph != PH_COLLECT) begin
          pieces_due.push_back(refusal);
        end else begin
          if (batch_len < BATCH_MAX) begin
            batch_mem[batch_len] = {stage, idx};
            batch_len++;
          end
          if (batch_len >= BATCH_MAX) try_flush();
        end
      end
      MODE_FLUSH: begin
        if (ph == PH_COLLECT) try_flush();
      end
      MODE_CLOSE: begin
        // A close while a flush is held queues behind it; later closes are ignored.
        if (ph == PH_HOLD) begin
          ph = PH_CLOSE_HOLD;
        end else if (ph == PH_COLLECT) begin
          if (batch_len > 0) begin
            if (acked_now) begin
              ph = PH_CLOSE_WAIT;
              launch_batch();
            end else begin
              ph = PH_CLOSE_HOLD;
            end
          end else if (acked_now) begin
            ph = PH_END_WAIT;
            launch_batch();
          end else begin
            ph = PH_CLOSE_WAIT;
          end
        end
      end
      MODE_ACK: begin
        if (ph != PH_DONE && aseq == seq_now && achip == want_chip &&
            aport == 8'(32 + want_core)) begin
          acked_now = 1'b1;
          case (ph)
            PH_HOLD: begin
              ph = PH_COLLECT;
              launch_batch();
            end
            PH_CLOSE_HOLD: begin
              ph = PH_CLOSE_WAIT;
              launch_batch();
            end
            PH_CLOSE_WAIT: begin
              batch_len = 0;
              ph = PH_END_WAIT;
              launch_batch();
            end
            PH_END_WAIT: ph = PH_DONE;
            default: ;
          endcase
        end
      end
      MODE_TICK: begin
        if (!acked_now && ph >= PH_HOLD && ph <= PH_END_WAIT) queue_flight_copy();
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Rising edge: register writes, accepted commands and result transfers.

  always @(posedge clk) begin : watch_transfers
    piece_t got;
    piece_t want;
    in_took  = rst_n && in_valid && !in_stall;
    res_took = rst_n && out_valid && !out_stall;
    if (!rst_n) begin
      batch_len = 0;
      flight_len = 0;
      seq_now = SEQ_RESET;
      acked_now = 1'b1;
      ph = PH_COLLECT;
      want_chip = '0;
      want_core = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DEST_CHIP) want_chip = cfg_wdata;
        else want_core = cfg_wdata[4:0];
      end
      // Results are checked first: none can stem from a command taken this edge.
      if (res_took) begin
        got.kind = out_kind;
        got.seq  = out_packet_sequence;
        got.cnt  = out_packet_count;
        got.ent  = {out_entry_d, out_entry_c, out_entry_b, out_entry_a};
        got.last = out_piece_last;
        if (got.kind == KIND_REFUSE) refusals_seen++;
        else pieces_seen++;
        if (pieces_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result: kind %0d sequence %0h count %0d",
                                    got.kind, got.seq, got.cnt));
        end else begin
          want = pieces_due.pop_front();
          compare_field("kind", got.kind, want.kind);
          compare_field("packet_sequence", got.seq, want.seq);
          compare_field("packet_count", got.cnt, want.cnt);
          compare_field("entry_a", got.ent[0], want.ent[0]);
          compare_field("entry_b", got.ent[1], want.ent[1]);
          compare_field("entry_c", got.ent[2], want.ent[2]);
          compare_field("entry_d", got.ent[3], want.ent[3]);
          compare_field("piece_last", got.last, want.last);
          if (want.kind == KIND_PIECE && want.last) begin
            packets_seen++;
            if (want.cnt == BATCH_MAX) full_packets++;
          end
        end
      end
      if (in_took) begin
        cmds_taken++;
        sender_advance(in_mode, in_neuron_index, in_delay_stage, in_ack_sequence,
                       in_ack_source_chip, in_ack_source_port);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Falling edge: command driver. Acknowledgement fields that must match are
  // filled in from the predicted state, which is current once the previous
  // transfer has been taken.

  always @(negedge clk) begin : drive_commands
    cmd_item_t it;
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmds_waiting.size() > 0) begin
        it = cmds_waiting.pop_front();
        if (it.form != AK_RAW) begin
          it.aseq  = seq_now;
          it.achip = want_chip;
          it.aport = 8'(32 + want_core);
          case (it.form)
            AK_SEQ_OFF:  it.aseq  = it.aseq ^ 16'($urandom_range(1, 16'hFFFF));
            AK_CHIP_OFF: it.achip = it.achip ^ 16'($urandom_range(1, 16'hFFFF));
            AK_PORT_OFF: it.aport = it.aport ^ 8'($urandom_range(1, 8'hFF));
            default: ;
          endcase
        end
        in_mode            <= it.mode;
        in_neuron_index    <= it.idx;
        in_delay_stage     <= it.stage;
        in_ack_sequence    <= it.aseq;
        in_ack_source_chip <= it.achip;
        in_ack_source_port <= it.aport;
        in_valid           <= 1'b1;
        gap_left = calm_in ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Falling edge: receiver stall, drawn afresh after every result transfer.
  always @(negedge clk) begin : drive_stall
    if (res_took) stall_left = calm_out ? 0 : $urandom_range(0, MAX_WAIT);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d commands queued, %0d results outstanding",
               cycle_count, cmds_waiting.size(), pieces_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers

  function automatic cmd_item_t fresh_item(logic [2:0] mode);
    cmd_item_t it;
    it.mode  = mode;
    it.idx   = 8'($urandom);
    it.stage = 8'($urandom);
    it.aseq  = 16'($urandom);
    it.achip = 16'($urandom);
    it.aport = 8'($urandom);
    it.form  = AK_RAW;
    return it;
  endfunction

  task automatic push_cmd(logic [2:0] mode, ack_form_t form = AK_RAW);
    cmd_item_t it;
    it = fresh_item(mode);
    it.form = form;
    cmds_waiting.push_back(it);
  endtask

  task automatic push_entry(logic [7:0] idx, logic [7:0] stage);
    cmd_item_t it;
    it = fresh_item(MODE_ADD);
    it.idx = idx;
    it.stage = stage;
    cmds_waiting.push_back(it);
  endtask

  task automatic push_entries(int n);
    for (int i = 0; i < n; i++) push_cmd(MODE_ADD);
  endtask

  // Mostly entries, with flushes, acknowledgements (good, near misses and
  // random), ticks and undefined modes mixed in.
  task automatic queue_traffic(int n, int add_pct, int flush_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
        push_cmd(MODE_ADD);
      end else begin
        r = $urandom_range(0, 99);
        if (r < flush_pct) push_cmd(MODE_FLUSH);
        else if (r < flush_pct + 35) push_cmd(MODE_ACK, AK_GOOD);
        else if (r < flush_pct + 50)
          push_cmd(MODE_ACK, ack_form_t'($urandom_range(int'(AK_SEQ_OFF), int'(AK_PORT_OFF))));
        else if (r < flush_pct + 75) push_cmd(MODE_TICK);
        else if (r < flush_pct + 83) push_cmd(MODE_ACK);
        else push_cmd(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)));
      end
    end
  endtask

  // Hold the sender until every command is taken and every result has arrived,
  // then give the core time to finish any command without a result.
  task automatic wait_quiet();
    do @(posedge clk);
    while (!(cmds_waiting.size() == 0 && !in_valid && pieces_due.size() == 0));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // The core register takes the low five bits; the upper bits carry noise.
  task automatic set_destination(logic [15:0] chip, logic [4:0] core);
    write_reg(CFG_DEST_CHIP, chip);
    write_reg(CFG_DEST_CORE, {11'($urandom), core});
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence

  initial begin : stimulus
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    set_destination(16'hFFFF, 5'd31);

    // Directed: empty flush, idle tick, entry extremes, a two-piece packet,
    // a held flush with refusal and resend, near-miss acknowledgements,
    // undefined modes and the release of the held send.
    push_cmd(MODE_FLUSH);
    push_cmd(MODE_TICK);
    push_entry(8'h00, 8'h00);
    push_entry(8'hFF, 8'hFF);
    push_entry(8'hA5, 8'h5A);
    push_entry(8'h5A, 8'hA5);
    push_entry(8'h01, 8'h80);
    push_cmd(MODE_FLUSH);
    push_entry(8'h7F, 8'hFE);
    push_cmd(MODE_FLUSH);
    push_cmd(MODE_ADD);
    push_cmd(MODE_FLUSH);
    push_cmd(MODE_TICK);
    push_cmd(MODE_ACK, AK_SEQ_OFF);
    push_cmd(MODE_ACK, AK_CHIP_OFF);
    push_cmd(MODE_ACK, AK_PORT_OFF);
    push_cmd(MODE_SPARE_FIRST);
    push_cmd(MODE_SPARE_LAST);
    push_cmd(MODE_ACK, AK_GOOD);
    push_cmd(MODE_TICK);
    push_cmd(MODE_ACK, AK_GOOD);
    push_cmd(MODE_ACK, AK_GOOD);
    wait_quiet();

    // Mixed traffic with random idling on both sides.
    set_destination(16'h0000, 5'd0);
    queue_traffic(100, 55, 15);
    wait_quiet();

    // Long runs of entries sent back to back, so that batches fill completely.
    set_destination(16'($urandom), 5'($urandom));
    calm_in = 1'b1;
    queue_traffic(260, 90, 0);
    wait_quiet();
    calm_in = 1'b0;

    // Mixed traffic into a receiver that never stalls.
    set_destination(16'($urandom), 5'($urandom));
    calm_out = 1'b1;
    queue_traffic(100, 60, 15);
    wait_quiet();
    calm_out = 1'b0;

    // Bring the sender to an empty, acknowledged batch before closing.
    set_destination(16'($urandom), 5'($urandom));
    while (ph != PH_COLLECT || !acked_now || batch_len != 0) begin
      if (batch_len != 0) push_cmd(MODE_FLUSH);
      push_cmd(MODE_ACK, AK_GOOD);
      wait_quiet();
    end

    // Close along one of the paths, then walk through to the end.
    ending = close_path_t'($urandom_range(int'(END_EMPTY), int'(END_EMPTY_UNACKED)));
    case (ending)
      END_REMAINDER: push_entries($urandom_range(1, 9));
      END_BEHIND_ACK: begin
        push_entries($urandom_range(1, 9));
        push_cmd(MODE_FLUSH);
        push_entries($urandom_range(1, 9));
      end
      END_BEHIND_HOLD: begin
        push_entries($urandom_range(1, 9));
        push_cmd(MODE_FLUSH);
        push_entries($urandom_range(1, 9));
        push_cmd(MODE_FLUSH);
      end
      END_EMPTY_UNACKED: begin
        push_entries($urandom_range(1, 9));
        push_cmd(MODE_FLUSH);
      end
      default: ;
    endcase
    push_cmd(MODE_CLOSE);
    push_cmd(MODE_TICK);
    push_cmd(MODE_ADD);
    push_cmd(MODE_FLUSH);
    push_cmd(MODE_CLOSE);
    push_cmd(MODE_ACK, AK_SEQ_OFF);
    for (int i = 0; i < 3; i++) begin
      push_cmd(MODE_TICK);
      push_cmd(MODE_ACK, AK_GOOD);
    end
    // Once finished, only refused entries produce anything.
    push_cmd(MODE_ADD);
    push_cmd(MODE_ACK, AK_GOOD);
    push_cmd(MODE_TICK);
    push_cmd(MODE_CLOSE);
    push_cmd(MODE_FLUSH);
    push_cmd(MODE_SPARE_LAST);
    wait_quiet();
    repeat (END_CYCLES) @(posedge clk);

    $display("Covered %0d command transfers, %0d packet pieces in %0d packets (%0d full), %0d refusals.",
             cmds_taken, pieces_seen, packets_seen, full_packets, refusals_seen);
    $display("Closed via %s, last sequence %0d, %0d mismatches.", ending.name(), seq_now, errors);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
